[hdl/dfucre_pkg.sv]
// Package for the DFU class request engine: beat types, request and state codes.
// Used by the channel interfaces, the engine core and the top level.
`timescale 1ns / 1ps

package dfucre_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BYTES = 1'd1;

    localparam logic [31:0] FLASH_BASE_RST  = 32'd16384;
    localparam logic [31:0] FLASH_BYTES_RST = 32'd507904;

    // Event kinds.
    localparam logic [1:0] FUNC_SETUP    = 2'd0;
    localparam logic [1:0] FUNC_COMPLETE = 2'd1;
    localparam logic [1:0] FUNC_BUSRESET = 2'd2;

    localparam logic [6:0] CLASS_IFACE_TYPE = 7'h21;

    // bRequest codes.
    localparam logic [7:0] REQ_DETACH    = 8'd0;
    localparam logic [7:0] REQ_DNLOAD    = 8'd1;
    localparam logic [7:0] REQ_UPLOAD    = 8'd2;
    localparam logic [7:0] REQ_GETSTATUS = 8'd3;
    localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
    localparam logic [7:0] REQ_GETSTATE  = 8'd5;
    localparam logic [7:0] REQ_ABORT     = 8'd6;

    // DFU state numbering.
    typedef logic [3:0] t_dfu_state;
    localparam t_dfu_state ST_APP_IDLE      = 4'd0;
    localparam t_dfu_state ST_DFU_IDLE      = 4'd2;
    localparam t_dfu_state ST_DNLOAD_SYNC   = 4'd3;
    localparam t_dfu_state ST_DNLOAD_IDLE   = 4'd5;
    localparam t_dfu_state ST_MANIFEST_SYNC = 4'd6;
    localparam t_dfu_state ST_MANIFEST      = 4'd7;
    localparam t_dfu_state ST_WAIT_RESET    = 4'd8;
    localparam t_dfu_state ST_UPLOAD_IDLE   = 4'd9;
    localparam t_dfu_state ST_ERROR         = 4'd10;

    // bStatus codes.
    localparam logic [3:0] STAT_OK      = 4'd0;
    localparam logic [3:0] STAT_ERRPROG = 4'd6;
    localparam logic [3:0] STAT_ERRADDR = 4'd8;

    // Reply kinds.
    localparam logic [2:0] RK_NONE     = 3'd0;
    localparam logic [2:0] RK_STATUS   = 3'd1;
    localparam logic [2:0] RK_STATE    = 3'd2;
    localparam logic [2:0] RK_UPLOAD   = 3'd3;
    localparam logic [2:0] RK_ZLP      = 3'd4;
    localparam logic [2:0] RK_DNBUFFER = 3'd5;

    localparam logic [23:0] POLL_TIMEOUT_MS = 24'd500;
    localparam logic [15:0] STATUS_LEN      = 16'd6;
    localparam logic [15:0] STATE_LEN       = 16'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] block_number;
        logic [15:0] transfer_length;
        logic        write_ok;
    } t_event;

    typedef struct packed {
        logic [2:0]  reply_kind;
        logic [15:0] reply_length;
        logic [31:0] flash_address;
        logic        write_request;
        logic [3:0]  status_code;
        logic [23:0] poll_timeout;
        logic [3:0]  pending_state;
        logic [3:0]  device_state;
        logic        disconnect;
        logic        system_reset;
        logic        done_res;
    } t_reply;

endpackage

[hdl/dfucre_if.sv]
// Valid/ready channel interfaces for the event input and the reply output.
// Depends on dfucre_pkg for the beat types.
`timescale 1ns / 1ps

interface dfucre_in_if;
    import dfucre_pkg::*;
    logic   valid;
    logic   ready;
    t_event payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dfucre_out_if;
    import dfucre_pkg::*;
    logic   valid;
    logic   ready;
    t_reply payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/dfu_class_request_engine.sv]
// Top level of the DFU class request engine: input beat register, core, reply register.
// Depends on dfucre_pkg, dfucre_if and dfucre_core.
`timescale 1ns / 1ps

// One event beat is taken per clock and its reply leaves from the reply register: the beat is
// first captured in an input register, then decoded against the current DFU state in a
// single pass and written to the reply register, at which point the state, status and
// flash offset registers are updated too. Throughput is one event per cycle as long as the
// reply side keeps taking beats; a stalled reply holds both registers and lowers ready
// only once the input register is also occupied. Configuration writes take effect at
// the clock edge of the write and should be made while no event is in flight.
module dfu_class_request_engine
    import dfucre_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dfucre_in_if.sink             i_req,
    dfucre_out_if.source          o_rsp
);

    logic   r_in_valid;
    t_event r_in;
    logic   r_out_valid;
    t_reply r_out;

    logic   advance;
    logic   fire;
    logic   in_take;
    t_reply reply;

    assign advance     = !r_out_valid || o_rsp.ready;
    assign fire        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_req.payload;
        end
    end

    dfucre_core #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_event     (r_in),
        .o_reply     (reply)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= reply;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // The done flag is set exactly when the reported device state is wait-reset.
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.done_res == (r_out.device_state == ST_WAIT_RESET)))
        else $error("done flag does not match device state");

    // A held reply beat keeps its payload while the sink stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("reply changed while stalled");

    // Ready drops only when both registers hold beats and the sink stalls.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_in_valid && r_out_valid && !o_rsp.ready))
        else $error("input stalled without back-pressure");

endmodule

[hdl/dfucre_core.sv]
// DFU request engine core: configuration and state registers plus the event decode.
// Depends on dfucre_pkg. The reply is combinational from the current state and event.
`timescale 1ns / 1ps

module dfucre_core
    import dfucre_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_fire,
    input  t_event                i_event,
    output t_reply                o_reply
);

    localparam int PROD_W = 16 + $clog2(BLOCK_BYTES + 1);
    localparam logic [PROD_W-1:0] BLK_MUL = PROD_W'(BLOCK_BYTES);

    logic [31:0] r_flash_base;
    logic [31:0] r_flash_bytes;
    t_dfu_state  r_dev;
    t_dfu_state  r_pend;
    logic [3:0]  r_status;
    logic [31:0] r_offset;

    t_dfu_state  n_dev;
    t_dfu_state  n_pend;
    logic [3:0]  n_status;
    logic [31:0] n_offset;

    logic              ours;
    logic [PROD_W-1:0] blk_prod;
    logic [31:0]       blk_off;
    logic [32:0]       end_sum;
    logic              fits;
    logic              addr_fixed;
    logic [2:0]        kind;
    logic [15:0]       rlen;
    logic              wreq;
    logic              disc;
    logic              sysr;
    logic [31:0]       addr_off;

    assign ours     = (i_event.request_type[6:0] == CLASS_IFACE_TYPE);
    assign blk_prod = PROD_W'(i_event.block_number) * BLK_MUL;
    assign blk_off  = 32'(blk_prod);
    // Range check on the full sum, with no wrap at 32 bits.
    assign end_sum  = {1'b0, blk_off} + {17'b0, i_event.transfer_length};
    assign fits     = (end_sum <= {1'b0, r_flash_bytes});

    always_comb begin
        n_dev      = r_dev;
        n_pend     = r_pend;
        n_status   = r_status;
        n_offset   = r_offset;
        kind       = RK_NONE;
        rlen       = 16'd0;
        wreq       = 1'b0;
        disc       = 1'b0;
        sysr       = 1'b0;
        addr_fixed = 1'b0;
        unique case (i_event.func)
            FUNC_SETUP: begin
                if (ours) begin
                    unique case (i_event.request_code) inside
                        REQ_DNLOAD: begin
                            kind     = RK_DNBUFFER;
                            rlen     = i_event.transfer_length;
                            n_offset = blk_off;
                            if (i_event.transfer_length != 16'd0) begin
                                if (fits) begin
                                    n_dev  = ST_DNLOAD_SYNC;
                                    n_pend = ST_DNLOAD_IDLE;
                                end else begin
                                    n_dev    = ST_ERROR;
                                    n_status = STAT_ERRADDR;
                                    n_pend   = ST_ERROR;
                                end
                            end
                        end
                        REQ_UPLOAD: begin
                            n_dev    = ST_UPLOAD_IDLE;
                            n_offset = blk_off;
                            if (fits) begin
                                kind = RK_UPLOAD;
                                rlen = i_event.transfer_length;
                            end else begin
                                kind = RK_ZLP;
                            end
                        end
                        REQ_GETSTATUS: begin
                            kind = RK_STATUS;
                            rlen = STATUS_LEN;
                        end
                        REQ_CLRSTATUS, REQ_ABORT: begin
                            n_status = STAT_OK;
                            n_pend   = ST_DFU_IDLE;
                            n_offset = 32'd0;
                        end
                        REQ_GETSTATE: begin
                            kind = RK_STATE;
                            rlen = STATE_LEN;
                        end
                        default: ;
                    endcase
                end
            end
            FUNC_COMPLETE: begin
                if (ours) begin
                    unique case (i_event.request_code)
                        REQ_GETSTATUS: begin
                            n_dev = r_pend;
                            disc  = (r_pend == ST_WAIT_RESET);
                        end
                        REQ_DNLOAD: begin
                            if (i_event.transfer_length != 16'd0) begin
                                wreq       = 1'b1;
                                addr_fixed = 1'b1;
                                if (i_event.write_ok) begin
                                    n_offset = r_offset + {16'b0, i_event.transfer_length};
                                    n_pend   = ST_DNLOAD_IDLE;
                                end else begin
                                    n_status = STAT_ERRPROG;
                                    n_pend   = ST_ERROR;
                                end
                            end else begin
                                n_dev  = ST_MANIFEST_SYNC;
                                n_pend = ST_WAIT_RESET;
                            end
                        end
                        REQ_UPLOAD: begin
                            n_pend   = ST_UPLOAD_IDLE;
                            n_offset = r_offset + {16'b0, i_event.transfer_length};
                        end
                        default: ;
                    endcase
                end
            end
            FUNC_BUSRESET: begin
                if (r_dev == ST_WAIT_RESET || r_dev == ST_MANIFEST_SYNC ||
                    r_dev == ST_MANIFEST) begin
                    disc = 1'b1;
                    sysr = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // A block write reports the address it wrote, before the offset advances.
    assign addr_off = addr_fixed ? r_offset : n_offset;

    always_comb begin
        o_reply.reply_kind    = kind;
        o_reply.reply_length  = rlen;
        o_reply.flash_address = r_flash_base + addr_off;
        o_reply.write_request = wreq;
        o_reply.status_code   = n_status;
        o_reply.poll_timeout  = POLL_TIMEOUT_MS;
        o_reply.pending_state = n_pend;
        o_reply.device_state  = n_dev;
        o_reply.disconnect    = disc;
        o_reply.system_reset  = sysr;
        o_reply.done_res      = (n_dev == ST_WAIT_RESET);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_base  <= FLASH_BASE_RST;
            r_flash_bytes <= FLASH_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FLASH_BASE:  r_flash_base  <= i_cfg_data;
                CFG_FLASH_BYTES: r_flash_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev    <= ST_APP_IDLE;
            r_pend   <= ST_DFU_IDLE;
            r_status <= STAT_OK;
            r_offset <= 32'd0;
        end else if (i_fire) begin
            r_dev    <= n_dev;
            r_pend   <= n_pend;
            r_status <= n_status;
            r_offset <= n_offset;
        end
    end

    // A bus reset in manifest or wait-reset states always asks for a disconnect too.
    a_sysr_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply.system_reset |-> o_reply.disconnect)
        else $error("system reset without disconnect");

    // A block write never carries a data-stage reply.
    a_wreq_nokind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply.write_request |-> (o_reply.reply_kind == RK_NONE))
        else $error("write request with a reply");

    // State registers move only when an event is processed.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_fire) && $past(i_rst_n)) |-> ($stable(r_dev) && $stable(r_offset)))
        else $error("state changed without an event");

endmodule
